/* rtl/core/lbw_pkg.sv */
`timescale 1ns / 1ps

package lbw_pkg;

   localparam int STEP_BITS = 16;
   localparam int LEVEL_BITS = 7;
   localparam int CUR_BITS = 9;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [LEVEL_BITS-1:0] MIN_PEAK = 7'd10;
   localparam int INIT_LIMIT = 100;

   localparam logic [STEP_BITS-1:0] FADE_IN_RESET = 16'd1000;
   localparam logic [STEP_BITS-1:0] FADE_OUT_RESET = 16'd1000;
   localparam logic [STEP_BITS-1:0] HOLD_ON_RESET = 16'd500;
   localparam logic [STEP_BITS-1:0] HOLD_OFF_RESET = 16'd500;
   localparam logic [LEVEL_BITS-1:0] PEAK_RESET = 7'd0;
   localparam logic [LEVEL_BITS-1:0] DEFAULT_RESET = 7'd100;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FADE_IN_TIME   = 3'd0,
      CSR_FADE_OUT_TIME  = 3'd1,
      CSR_HOLD_ON_TIME   = 3'd2,
      CSR_HOLD_OFF_TIME  = 3'd3,
      CSR_PEAK_LEVEL     = 3'd4,
      CSR_DEFAULT_LEVEL  = 3'd5
   } lbw_csr_index_type;

   typedef struct packed {
      logic [STEP_BITS-1:0]  fade_in_time;
      logic [STEP_BITS-1:0]  fade_out_time;
      logic [STEP_BITS-1:0]  hold_on_time;
      logic [STEP_BITS-1:0]  hold_off_time;
      logic [LEVEL_BITS-1:0] peak_level;
      logic [LEVEL_BITS-1:0] default_level;
   } lbw_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lbw_div_status_type;

endpackage

/* rtl/core/lbw_csr.sv */
`timescale 1ns / 1ps

module lbw_csr import lbw_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output lbw_cfg_type               cfg
);

   lbw_cfg_type cfg_ff;
   lbw_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FADE_IN_TIME:  cfg_in.fade_in_time = csr_wdata;
            CSR_FADE_OUT_TIME: cfg_in.fade_out_time = csr_wdata;
            CSR_HOLD_ON_TIME:  cfg_in.hold_on_time = csr_wdata;
            CSR_HOLD_OFF_TIME: cfg_in.hold_off_time = csr_wdata;
            CSR_PEAK_LEVEL:    cfg_in.peak_level = csr_wdata[LEVEL_BITS-1:0];
            CSR_DEFAULT_LEVEL: cfg_in.default_level = csr_wdata[LEVEL_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fade_in_time <= FADE_IN_RESET;
         cfg_ff.fade_out_time <= FADE_OUT_RESET;
         cfg_ff.hold_on_time <= HOLD_ON_RESET;
         cfg_ff.hold_off_time <= HOLD_OFF_RESET;
         cfg_ff.peak_level <= PEAK_RESET;
         cfg_ff.default_level <= DEFAULT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/lbw_div.sv */
`timescale 1ns / 1ps

module lbw_div import lbw_pkg::*; #(
   parameter int WIDTH = 32,
   localparam int CW = $clog2(WIDTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CW-1:0]        iters,
   input  logic [WIDTH-1:0]     dividend,
   input  logic [STEP_BITS-1:0] divisor,
   output lbw_div_status_type   status,
   output logic [WIDTH-1:0]     quotient,
   output logic [STEP_BITS-1:0] remainder
);

   logic [WIDTH-1:0]     dvd_ff, dvd_in;
   logic [STEP_BITS-1:0] rem_ff, rem_in;
   logic [STEP_BITS-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS:0]   shifted;
   logic                 take;

   always_comb begin
      shifted = {rem_ff, dvd_ff[WIDTH-1]};
      take = shifted >= {1'b0, dsr_ff};
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? STEP_BITS'(shifted - {1'b0, dsr_ff}) : shifted[STEP_BITS-1:0];
         dvd_in = {dvd_ff[WIDTH-2:0], take};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient = dvd_ff;
   assign remainder = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("remainder not below divisor");

   a_no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start)
      else $error("divider restarted while busy");

endmodule

/* rtl/core/led_breathing_wave_core.sv */
`timescale 1ns / 1ps

// Breathing-light fade sequencer. One req_ transfer carries the current
// millisecond time stamp; each one yields zero or one rsp_ transfer with the
// level to drive and the fade direction. Configuration goes through the csr_
// write port and may be written only while the block is idle.
// An item that emits a level runs one shared restoring divider twice, one bit
// per cycle: 16 steps for the step time and TIME_BITS steps to split the
// elapsed time. An item that emits nothing goes back to idle after the
// evaluation step. req_stall is high from acceptance until the item is
// finished; one item is worked on at a time.
// The result sits in an output register: a stalled receiver holds it, and the
// next item is still accepted; only a second result then waits for the first
// transfer. Reset restores the register defaults, zeroes the schedule and
// the level and starts with a fade in.
module led_breathing_wave_core import lbw_pkg::*; #(
   parameter int TIME_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [31:0]               req_now_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [LEVEL_BITS-1:0]     rsp_level_percent,
   output logic                      rsp_fading_in,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int NOW_BITS = TIME_BITS < 32 ? TIME_BITS : 32;
   localparam int CW = $clog2(TIME_BITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV1,
      ST_DIV2,
      ST_OUT
   } state_type;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
   endfunction

   lbw_cfg_type        cfg;
   lbw_div_status_type div_status;
   logic [TIME_BITS-1:0] div_quotient;
   logic [STEP_BITS-1:0] div_remainder;
   logic                 div_start;
   logic [CW-1:0]        div_iters;
   logic [TIME_BITS-1:0] div_dividend;
   logic [STEP_BITS-1:0] div_divisor;

   state_type             state_ff, state_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [TIME_BITS-1:0]  nct_ff, nct_in;
   logic signed [CUR_BITS-1:0] cur_ff, cur_in;
   logic                  rising_ff, rising_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [LEVEL_BITS-1:0] emit_level_ff, emit_level_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic                  rsp_rising_ff, rsp_rising_in;

   logic [LEVEL_BITS-1:0] peak_eff;
   logic [LEVEL_BITS-1:0] peak_div;
   logic                  cur_above;
   logic [STEP_BITS-1:0]  step_new;
   logic [7:0]            q_sat;
   logic signed [10:0]    lvl_wide;
   logic signed [10:0]    lvl_top;

   lbw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lbw_div #(.WIDTH(TIME_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .iters     (div_iters),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      peak_eff = (cfg.peak_level < MIN_PEAK) ? cfg.default_level : cfg.peak_level;
      peak_div = (peak_eff == '0) ? LEVEL_BITS'(1) : peak_eff;
      cur_above = cur_ff > $signed({2'b00, peak_eff});
      step_new = (div_quotient[STEP_BITS-1:0] == '0) ? STEP_BITS'(1)
                                                      : div_quotient[STEP_BITS-1:0];
      q_sat = (|div_quotient[TIME_BITS-1:8]) ? 8'hFF : div_quotient[7:0];
      lvl_top = $signed({4'b0000, peak_eff}) + 11'sd1;
      if (rising_ff) begin
         lvl_wide = 11'(cur_ff) + $signed({3'b000, q_sat}) + 11'sd1;
      end else begin
         lvl_wide = 11'(cur_ff) - $signed({3'b000, q_sat}) - 11'sd1;
      end

      state_in = state_ff;
      now_in = now_ff;
      nct_in = nct_ff;
      cur_in = cur_ff;
      rising_in = rising_ff;
      step_in = step_ff;
      emit_level_in = emit_level_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_level_in = rsp_level_ff;
      rsp_rising_in = rsp_rising_ff;
      div_start = 1'b0;
      div_iters = CW'(STEP_BITS);
      div_dividend = TIME_BITS'(cfg.fade_in_time) << (TIME_BITS - STEP_BITS);
      div_divisor = STEP_BITS'(peak_div);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in = TIME_BITS'(req_now_ms[NOW_BITS-1:0]);
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_IDLE;
            if (now_ff > nct_ff) begin
               if (cur_above) begin
                  nct_in = sat_add(now_ff, TIME_BITS'(cfg.hold_on_time));
                  cur_in = $signed({2'b00, peak_eff});
                  rising_in = 1'b0;
               end else if (cur_ff[CUR_BITS-1]) begin
                  nct_in = sat_add(now_ff, TIME_BITS'(cfg.hold_off_time));
                  cur_in = '0;
                  rising_in = 1'b1;
               end else begin
                  if (nct_ff < TIME_BITS'(INIT_LIMIT)) begin
                     nct_in = now_ff;
                  end
                  emit_level_in = cur_ff[LEVEL_BITS-1:0];
                  div_start = 1'b1;
                  if (!rising_ff) begin
                     div_dividend = TIME_BITS'(cfg.fade_out_time) << (TIME_BITS - STEP_BITS);
                  end
                  state_in = ST_DIV1;
               end
            end
         end
         ST_DIV1: begin
            if (div_status.done) begin
               step_in = step_new;
               div_start = 1'b1;
               div_iters = CW'(TIME_BITS);
               div_dividend = now_ff - nct_ff;
               div_divisor = step_new;
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_status.done) begin
               nct_in = sat_add(now_ff - TIME_BITS'(div_remainder), TIME_BITS'(step_ff));
               if (rising_ff) begin
                  cur_in = (lvl_wide > lvl_top) ? CUR_BITS'(lvl_top) : CUR_BITS'(lvl_wide);
               end else begin
                  cur_in = (lvl_wide < -11'sd1) ? -9'sd1 : CUR_BITS'(lvl_wide);
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = emit_level_ff;
               rsp_rising_in = rising_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nct_ff <= '0;
         cur_ff <= '0;
         rising_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         nct_ff <= nct_in;
         cur_ff <= cur_in;
         rising_ff <= rising_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff <= now_in;
      step_ff <= step_in;
      emit_level_ff <= emit_level_in;
      rsp_level_ff <= rsp_level_in;
      rsp_rising_ff <= rsp_rising_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_level_percent = rsp_level_ff;
   assign rsp_fading_in = rsp_rising_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV1 || state_ff == ST_DIV2))
      else $error("divider finished with no division pending");

   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV2) |-> (step_ff != '0))
      else $error("zero step time in elapsed-time division");

   a_level_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (cur_ff >= -9'sd1))
      else $error("level stepped below the lower mark");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import lbw_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = 80;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic                  fading_in;
   } fade_level_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [31:0]               req_now_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [LEVEL_BITS-1:0]     rsp_level_percent;
   logic                      rsp_fading_in;
   logic                      csr_wr_en = 1'b0;
   lbw_csr_index_type         csr_index = CSR_FADE_IN_TIME;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // fade sequencer state as the block should hold it
   logic [STEP_BITS-1:0]  cfg_fade_in;
   logic [STEP_BITS-1:0]  cfg_fade_out;
   logic [STEP_BITS-1:0]  cfg_hold_on;
   logic [STEP_BITS-1:0]  cfg_hold_off;
   logic [LEVEL_BITS-1:0] cfg_peak;
   logic [LEVEL_BITS-1:0] cfg_default;
   logic [31:0]           sched_ms;
   int                    level_q;
   bit                    rising_q;

   fade_level_type pending_levels[$];
   logic [31:0] ms_now = '0;
   bit          idle_enable = 1'b1;
   int          fail_count = 0;
   int          cycle_count = 0;
   int          stall_left = 0;
   bit          stall_on = 1'b0;

   led_breathing_wave_core #(.TIME_BITS(32)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_level_percent (rsp_level_percent),
      .rsp_fading_in     (rsp_fading_in),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_on = idle_enable && ($urandom_range(0, 99) < 35);
         stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 4);
      end
      stall_left--;
      rsp_stall <= stall_on;
   end

   always @(posedge clock) begin
      fade_level_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_levels.size() == 0) begin
            $error("unexpected transfer: level_percent %0d fading_in %0d",
                   rsp_level_percent, rsp_fading_in);
            fail_count++;
         end else begin
            want = pending_levels.pop_front();
            if (rsp_level_percent !== want.level) begin
               $error("level_percent: expected %0d, got %0d", want.level, rsp_level_percent);
               fail_count++;
            end
            if (rsp_fading_in !== want.fading_in) begin
               $error("fading_in: expected %0d, got %0d", want.fading_in, rsp_fading_in);
               fail_count++;
            end
         end
      end
   end

   function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   function automatic int effective_peak();
      return (cfg_peak < MIN_PEAK) ? int'(cfg_default) : int'(cfg_peak);
   endfunction

   function automatic logic [31:0] fade_step_ms();
      int          peak;
      logic [31:0] step;
      peak = effective_peak();
      if (peak < 1)
         peak = 1;
      step = (rising_q ? cfg_fade_in : cfg_fade_out) / $unsigned(peak);
      if (step == 0)
         step = 1;
      return step;
   endfunction

   task automatic advance_fade(input logic [31:0] now);
      int             peak;
      logic [31:0]    step;
      logic [31:0]    diff;
      longint         moves;
      fade_level_type lvl;
      peak = effective_peak();
      if (now > sched_ms) begin
         if (level_q > peak) begin
            sched_ms = add_clamped(now, cfg_hold_on);
            level_q = peak;
            rising_q = 1'b0;
         end else if (level_q < 0) begin
            sched_ms = add_clamped(now, cfg_hold_off);
            level_q = 0;
            rising_q = 1'b1;
         end else begin
            if (sched_ms < INIT_LIMIT)
               sched_ms = now;
            lvl.level = level_q[LEVEL_BITS-1:0];
            lvl.fading_in = rising_q;
            pending_levels.push_back(lvl);
            step = fade_step_ms();
            diff = now - sched_ms;
            sched_ms = add_clamped(now - diff % step, step);
            moves = longint'(diff / step) + 1;
            if (moves > peak + 2)
               moves = peak + 2;
            if (rising_q)
               level_q = (level_q + moves > peak + 1) ? peak + 1 : int'(level_q + moves);
            else
               level_q = (level_q - moves < -1) ? -1 : int'(level_q - moves);
         end
      end
   endtask

   task automatic send_time(input logic [31:0] stamp);
      int gap;
      int r;
      gap = 0;
      if (idle_enable) begin
         r = $urandom_range(0, 99);
         if (r >= 97)
            gap = $urandom_range(20, 60);
         else if (r >= 75)
            gap = $urandom_range(1, 4);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= stamp;
      do @(posedge clock); while (req_stall);
      advance_fade(stamp);
   endtask

   task automatic tick(input logic [31:0] incr);
      ms_now = ms_now + incr;
      send_time(ms_now);
   endtask

   task automatic near_change(input logic [31:0] offset);
      ms_now = ((ms_now > sched_ms) ? ms_now : sched_ms) + offset;
      send_time(ms_now);
   endtask

   task automatic drain_levels();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_levels.size() != 0);
   endtask

   task automatic settle_idle();
      drain_levels();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input lbw_csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [STEP_BITS-1:0] fade_in, fade_out,
                                 input logic [STEP_BITS-1:0] hold_on, hold_off,
                                 input logic [LEVEL_BITS-1:0] peak, dflt);
      put_reg(CSR_FADE_IN_TIME, fade_in);
      put_reg(CSR_FADE_OUT_TIME, fade_out);
      put_reg(CSR_HOLD_ON_TIME, hold_on);
      put_reg(CSR_HOLD_OFF_TIME, hold_off);
      put_reg(CSR_PEAK_LEVEL, {{(CSR_DATA_BITS-LEVEL_BITS){1'b0}}, peak});
      put_reg(CSR_DEFAULT_LEVEL, {{(CSR_DATA_BITS-LEVEL_BITS){1'b0}}, dflt});
      csr_wr_en <= 1'b0;
      cfg_fade_in = fade_in;
      cfg_fade_out = fade_out;
      cfg_hold_on = hold_on;
      cfg_hold_off = hold_off;
      cfg_peak = peak;
      cfg_default = dflt;
   endtask

   function automatic logic [STEP_BITS-1:0] pick_ms(input int typical);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return STEP_BITS'($urandom_range(0, typical));
      endcase
   endfunction

   task automatic randomise_settings();
      logic [LEVEL_BITS-1:0] peak;
      logic [LEVEL_BITS-1:0] dflt;
      case ($urandom_range(0, 7))
         0: peak = 7'd0;
         1: peak = MIN_PEAK - 7'd1;
         2: peak = MIN_PEAK;
         3: peak = 7'd100;
         default: peak = LEVEL_BITS'($urandom_range(0, 100));
      endcase
      case ($urandom_range(0, 5))
         0: dflt = 7'd1;
         1: dflt = 7'd100;
         default: dflt = LEVEL_BITS'($urandom_range(1, 100));
      endcase
      write_settings(pick_ms(3000), pick_ms(3000), pick_ms(400), pick_ms(400), peak, dflt);
   endtask

   // reset schedule, catch-up, both holds, with the reset register values
   task automatic test_reset_schedule();
      logic [31:0] stamps[] = '{32'd0, 32'd1, 32'd5, 32'd11, 32'd12, 32'd500, 32'd2000,
                                32'd2001, 32'd2002, 32'd2503, 32'd2600, 32'd9000,
                                32'd9100, 32'd9601};
      foreach (stamps[i])
         send_time(stamps[i]);
      ms_now = stamps[stamps.size()-1];
   endtask

   task automatic test_register_extremes();
      settle_idle();
      write_settings('0, '0, '0, '0, MIN_PEAK - 7'd1, 7'd1);
      repeat (4) tick(1);
      tick(10);
      settle_idle();
      write_settings('1, '1, '1, '1, MIN_PEAK, 7'd100);
      repeat (3) near_change(1);
      settle_idle();
      write_settings(16'd1000, 16'd1000, 16'd500, 16'd500, 7'd100, 7'd100);
      near_change(0);
      near_change(1);
      tick(3000);
   endtask

   task automatic test_random_fades(input int phase_count, input int per_phase);
      int sent;
      int r;
      for (int p = 0; p < phase_count; p++) begin
         settle_idle();
         idle_enable = (p % 4 != 1);
         randomise_settings();
         if (p == phase_count / 2)
            ms_now = ms_now + 32'h8000_0000;
         sent = 0;
         while (sent < per_phase) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               send_time($urandom_range(0, sched_ms));
            end else if (r < 7) begin
               drain_levels();
            end else begin
               sent++;
               if (r < 62)
                  tick($urandom_range(0, fade_step_ms() + 1));
               else if (r < 90)
                  near_change($urandom_range(0, 3));
               else
                  tick($urandom_range(0, 70000));
            end
         end
      end
      idle_enable = 1'b1;
   endtask

   // drive the change time into saturation, then wrap the time stamp
   task automatic test_time_wrap();
      logic [31:0] stamps[] = '{32'hFFFE_0000, 32'hFFFE_0001, 32'hFFFF_0000, 32'hFFFF_F000,
                                32'hFFFF_FFFF, 32'h0000_0005, 32'h0001_0000, 32'hFFFF_FFFF};
      settle_idle();
      write_settings('1, '1, '1, '1, MIN_PEAK, 7'd100);
      foreach (stamps[i])
         send_time(stamps[i]);
   endtask

   initial begin
      cfg_fade_in = FADE_IN_RESET;
      cfg_fade_out = FADE_OUT_RESET;
      cfg_hold_on = HOLD_ON_RESET;
      cfg_hold_off = HOLD_OFF_RESET;
      cfg_peak = PEAK_RESET;
      cfg_default = DEFAULT_RESET;
      sched_ms = '0;
      level_q = 0;
      rising_q = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_schedule();
      test_register_extremes();
      test_random_fades(12, 140);
      test_time_wrap();

      drain_levels();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
